>>> sv/scint_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scint_pkg
// Shared constants, register codes and status codes for the scintillator bar
// event reconstruction pipeline.
// ----------------------------------------------------------------------------
package scint_pkg;

  // fixed point formats
  localparam int FRAC_BITS = 10;
  localparam int GAIN_FRAC = 16;
  localparam int LOG_FRAC  = 28;

  // port widths
  localparam int IN_DW    = 120;
  localparam int IN_UW    = 8;
  localparam int OUT_DW   = 88;
  localparam int OUT_UW   = 2;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 24;
  localparam int RES_W    = 21;
  localparam int ENERGY_W = 25;

  // configuration register index
  typedef enum logic [CFG_AW-1:0] {
    CFG_TIME_GAIN   = 2'd0,
    CFG_TIME_OFFSET = 2'd1,
    CFG_ATTEN_SCALE = 2'd2,
    CFG_TOF_ZERO    = 2'd3
  } cfg_idx_t;

  // result status
  typedef enum logic [OUT_UW-1:0] {
    ST_OK          = 2'd0,
    ST_ZERO_CHARGE = 2'd1,
    ST_BAD_FLIGHT  = 2'd2,
    ST_SATURATED   = 2'd3
  } status_t;

  localparam logic [IN_UW-1:0] PID_NEUTRON = 8'd1;

  // register reset values
  localparam logic signed [23:0] GAIN_RST  = -24'sd245651;
  localparam logic signed [20:0] OFFS_RST  = -21'sd56334;
  localparam logic [19:0]        ATTEN_RST = 20'd386283;
  localparam logic [19:0]        TOFZ_RST  = 20'd43978;

  // calibration constants
  localparam int TOF_SHIFT_Q = ((16748 << FRAC_BITS) + 500) / 1000;
  localparam int PATH_BASE_Q = (1005 << FRAC_BITS) >> 1;
  localparam logic [63:0] PATH_BASE_SQ = 64'(PATH_BASE_Q) * 64'(PATH_BASE_Q);
  localparam logic signed [31:0] LN2_Q30 = 32'sd744261118;
  localparam logic [43:0] ENERGY_NUM = 44'd5184 << (3 * FRAC_BITS);
  localparam logic [6:0]  FLIGHT_SCALE = 7'd100;

  // output limits
  localparam int OUT_MAX = 1048575;
  localparam int OUT_MIN = -1048576;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX  = 25'd16777215;
  localparam logic [ENERGY_W-1:0] ENERGY_NONE = 25'(-(1 << FRAC_BITS));

endpackage

>>> sv/scintillator_event_reconstruct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scintillator_event_reconstruct
// Two-ended scintillator bar event reconstruction: time and charge hit
// position, path-corrected flight time and neutron energy, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  in_       slave      tdata: time_up, time_down, charge_up, charge_down,
//                       raw_flight; tuser: particle_id
//  out_      master     tdata: pos_time, pos_charge, flight_per_metre,
//                       energy; tuser: status
//  cfg_      write      index 0..3: time_gain, time_offset, atten_scale, tof_zero
//
//  one event enters per cycle while the output is not held; the depth is set by
//  the 21-step square root, the 20-step flight divider and the 24-step energy
//  divider in series on the time path (the 28-squaring log2 lanes run alongside)
//  rst_n clears the valid bits and loads the register reset values
//  a held result at the output freezes the whole pipeline; in_tready is low
//  exactly then, so nothing is dropped or repeated
// ----------------------------------------------------------------------------
module scintillator_event_reconstruct (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [31:0] time_up, [63:32] time_down, [79:64] charge_up,
  // [95:80] charge_down, [115:96] raw_flight, [119:116] zero
  input  logic [scint_pkg::IN_DW-1:0]   in_tdata,
  // [7:0] particle_id
  input  logic [scint_pkg::IN_UW-1:0]   in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [20:0] pos_time, [41:21] pos_charge, [62:42] flight_per_metre,
  // [87:63] energy
  output logic [scint_pkg::OUT_DW-1:0]  out_tdata,
  // [1:0] status
  output logic [scint_pkg::OUT_UW-1:0]  out_tuser,
  input  logic                          cfg_we,
  input  logic [scint_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [scint_pkg::CFG_DW-1:0]  cfg_wdata
);
  import scint_pkg::*;

  localparam int LG_N    = LOG_FRAC;
  localparam int SQ_N    = 21;
  localparam int DV_N    = 20;
  localparam int EV_N    = 24;
  localparam int ST_SQ0  = 6;
  localparam int ST_DVS  = ST_SQ0 + SQ_N;
  localparam int ST_NTOF = ST_DVS + DV_N + 1;
  localparam int ST_N2   = ST_NTOF + 1;
  localparam int ST_EVS  = ST_N2 + 1;
  localparam int ST_LAST = ST_EVS + EV_N + 1;
  localparam int ST_DL   = 3 + LG_N;
  localparam int ST_POSQ = ST_DL + 4;
  localparam int SQV_W   = 42;
  localparam int SQR_W   = 43;
  localparam int DVD_W   = 39;

  // per-event fields that ride along the pipeline
  typedef struct packed {
    logic             nt;
    logic             zq;
    logic             neg;
    logic [20:0]      mag;
    logic [RES_W-1:0] pos_t;
    logic             sat_t;
    logic [RES_W-1:0] pos_q;
    logic             sat_q;
    logic [RES_W-1:0] ntof;
    logic             bad;
    logic             ovf;
  } side_t;

  // configuration registers
  logic signed [23:0] gain_r;
  logic signed [20:0] toff_r;
  logic [19:0]        atten_r;
  logic [19:0]        tofz_r;

  // pipeline control
  logic               en;
  logic               vld_r [1:ST_LAST];
  side_t              side_in_nxt;
  side_t              side_r   [1:ST_LAST-1];
  side_t              side_nxt [1:ST_LAST-1];

  // time position path
  logic signed [32:0] d1_r, d1_nxt;
  logic signed [40:0] pph2_r, pph2_nxt, ppl2_r, ppl2_nxt;
  logic signed [42:0] pr3_r, pr3_nxt;
  logic [SQV_W-1:0]   rad5_r, rad5_nxt;

  // log2 lanes, 0 up and 1 down
  logic [15:0]        q1_r [2];
  logic [30:0]        m2_r [2];
  logic [30:0]        m2_nxt [2];
  logic [31:0]        g2_r [2];
  logic [31:0]        g2_nxt [2];
  logic [30:0]        lm_r   [2][LG_N];
  logic [30:0]        lm_nxt [2][LG_N];
  logic [31:0]        lg_r   [2][LG_N];
  logic [31:0]        lg_nxt [2][LG_N];
  logic signed [32:0] dl_r, dl_nxt;
  logic signed [63:0] lnp_r, lnp_nxt;
  logic signed [34:0] ln_r, ln_nxt;
  logic signed [55:0] qp_r, qp_nxt;

  // square root stages
  logic [SQV_W-1:0]   sqv_r   [SQ_N];
  logic [SQV_W-1:0]   sqv_nxt [SQ_N];
  logic [SQR_W-1:0]   sqr_r   [SQ_N];
  logic [SQR_W-1:0]   sqr_nxt [SQ_N];

  // flight divider
  logic [20:0]        ds_rem_r, ds_rem_nxt, ds_div_r, ds_div_nxt;
  logic [DV_N-1:0]    ds_low_r, ds_low_nxt;
  logic [20:0]        dr_r [DV_N];
  logic [20:0]        dr_nxt [DV_N];
  logic [20:0]        dd_r [DV_N];
  logic [DV_N-1:0]    dlo_r [DV_N];
  logic [DV_N-1:0]    dq_r [DV_N];
  logic [DV_N-1:0]    dq_nxt [DV_N];

  // energy divider
  logic [39:0]        n2_r, n2_nxt;
  logic [43:0]        en_r, en_nxt;
  logic [39:0]        es_rem_r, es_rem_nxt, es_div_r;
  logic [EV_N-1:0]    es_low_r;
  logic [39:0]        er_r [EV_N];
  logic [39:0]        er_nxt [EV_N];
  logic [39:0]        ed_r [EV_N];
  logic [EV_N-1:0]    elo_r [EV_N];
  logic [EV_N-1:0]    eq_r [EV_N];
  logic [EV_N-1:0]    eq_nxt [EV_N];

  // output register
  logic [OUT_DW-1:0]  odata_r, odata_nxt;
  status_t            ostat_r, ostat_nxt;

  assign en         = !vld_r[ST_LAST] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[ST_LAST];
  assign out_tdata  = odata_r;
  assign out_tuser  = ostat_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RST;
      toff_r  <= OFFS_RST;
      atten_r <= ATTEN_RST;
      tofz_r  <= TOFZ_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_TIME_GAIN:   gain_r  <= cfg_wdata;
        CFG_TIME_OFFSET: toff_r  <= cfg_wdata[20:0];
        CFG_ATTEN_SCALE: atten_r <= cfg_wdata[19:0];
        CFG_TOF_ZERO:    tofz_r  <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // entry stage: time difference and flight numerator
  always_comb begin
    logic signed [31:0] tu, td;
    logic signed [21:0] num;
    tu = in_tdata[31:0];
    td = in_tdata[63:32];
    d1_nxt = 33'(tu) - 33'(td);
    num = $signed({2'b00, in_tdata[115:96]}) - $signed({2'b00, tofz_r})
        + 22'(TOF_SHIFT_Q);
    side_in_nxt     = '0;
    side_in_nxt.nt  = (in_tuser == PID_NEUTRON);
    side_in_nxt.zq  = (in_tdata[79:64] == 16'd0) || (in_tdata[95:80] == 16'd0);
    side_in_nxt.neg = num[21];
    side_in_nxt.mag = num[21] ? 21'(-num) : 21'(num);
  end

  // time position: split product, round, offset
  always_comb begin
    logic signed [57:0] v;
    pph2_nxt = gain_r * $signed(d1_r[32:16]);
    ppl2_nxt = gain_r * $signed({1'b0, d1_r[15:0]});
    v = (58'(pph2_r) <<< GAIN_FRAC) + 58'(ppl2_r) + (58'sd1 <<< (GAIN_FRAC - 1));
    pr3_nxt = 43'(v >>> GAIN_FRAC) + 43'(toff_r);
  end

  // path radicand from the clamped time position
  always_comb begin
    logic signed [41:0] sq;
    sq = $signed(side_r[4].pos_t) * $signed(side_r[4].pos_t);
    rad5_nxt = SQV_W'(PATH_BASE_SQ) + SQV_W'(sq);
  end

  // log2 normalization: leading one and mantissa in Q30
  always_comb begin
    logic [3:0]  e;
    logic [15:0] x;
    for (int l = 0; l < 2; l++) begin
      x = q1_r[l];
      e = 4'd0;
      for (int i = 0; i < 16; i++) begin
        if (x[i]) e = 4'(i);
      end
      m2_nxt[l] = 31'(x) << (5'd30 - 5'(e));
      g2_nxt[l] = {e, 28'd0};
    end
  end

  // log2 fraction, one squaring per stage
  always_comb begin
    logic [30:0] mi;
    logic [31:0] gi;
    logic [61:0] sq;
    logic [31:0] t;
    for (int l = 0; l < 2; l++) begin
      for (int j = 0; j < LG_N; j++) begin
        mi = (j == 0) ? m2_r[l] : lm_r[l][j-1];
        gi = (j == 0) ? g2_r[l] : lg_r[l][j-1];
        sq = mi * mi;
        t  = sq[61:30];
        if (t[31]) begin
          lm_nxt[l][j] = t[31:1];
          lg_nxt[l][j] = gi | (32'd1 << (LG_N - 1 - j));
        end else begin
          lm_nxt[l][j] = t[30:0];
          lg_nxt[l][j] = gi;
        end
      end
    end
  end

  // charge position: log difference, times ln2, times attenuation length
  always_comb begin
    dl_nxt  = $signed({1'b0, lg_r[0][LG_N-1]}) - $signed({1'b0, lg_r[1][LG_N-1]});
    lnp_nxt = dl_r * LN2_Q30;
    ln_nxt  = 35'((lnp_r + (64'sd1 <<< (LOG_FRAC - 1))) >>> LOG_FRAC);
    qp_nxt  = ln_r * $signed({1'b0, atten_r});
  end

  // square root, one result bit per stage
  always_comb begin
    logic [SQV_W-1:0] vi;
    logic [SQR_W-1:0] ri, bitv, t;
    for (int j = 0; j < SQ_N; j++) begin
      vi   = (j == 0) ? rad5_r : sqv_r[j-1];
      ri   = (j == 0) ? '0 : sqr_r[j-1];
      bitv = SQR_W'(1) << (2 * (SQ_N - 1 - j));
      t    = ri + bitv;
      if ({1'b0, vi} >= t) begin
        sqv_nxt[j] = vi - t[SQV_W-1:0];
        sqr_nxt[j] = (ri >> 1) + bitv;
      end else begin
        sqv_nxt[j] = vi;
        sqr_nxt[j] = ri >> 1;
      end
    end
  end

  // flight divider setup and restoring stages
  always_comb begin
    logic [27:0]      prod;
    logic [DVD_W-1:0] dvd;
    logic [20:0]      path, ri, dv;
    logic [21:0]      t;
    logic [DV_N-1:0]  lo, qi;
    path = sqr_r[SQ_N-1][20:0];
    prod = side_r[ST_DVS-1].mag * FLIGHT_SCALE;
    dvd  = (DVD_W'(prod) << FRAC_BITS) + DVD_W'(path >> 1);
    ds_rem_nxt = 21'(dvd >> DV_N);
    ds_low_nxt = dvd[DV_N-1:0];
    ds_div_nxt = path;
    for (int j = 0; j < DV_N; j++) begin
      ri = (j == 0) ? ds_rem_r : dr_r[j-1];
      dv = (j == 0) ? ds_div_r : dd_r[j-1];
      lo = (j == 0) ? ds_low_r : dlo_r[j-1];
      qi = (j == 0) ? '0 : dq_r[j-1];
      t  = {ri, lo[DV_N-1-j]};
      if (t >= {1'b0, dv}) begin
        dr_nxt[j] = 21'(t - {1'b0, dv});
        dq_nxt[j] = qi | (DV_N'(1) << (DV_N - 1 - j));
      end else begin
        dr_nxt[j] = t[20:0];
        dq_nxt[j] = qi;
      end
    end
  end

  // energy numerator and restoring stages
  always_comb begin
    logic [39:0]     ri, dv;
    logic [40:0]     t;
    logic [EV_N-1:0] lo, qi;
    n2_nxt = side_r[ST_N2-1].ntof[19:0] * side_r[ST_N2-1].ntof[19:0];
    en_nxt = ENERGY_NUM + 44'(n2_nxt >> 1);
    es_rem_nxt = 40'(en_r >> EV_N);
    for (int j = 0; j < EV_N; j++) begin
      ri = (j == 0) ? es_rem_r : er_r[j-1];
      dv = (j == 0) ? es_div_r : ed_r[j-1];
      lo = (j == 0) ? es_low_r : elo_r[j-1];
      qi = (j == 0) ? '0 : eq_r[j-1];
      t  = {ri, lo[EV_N-1-j]};
      if (t >= {1'b0, dv}) begin
        er_nxt[j] = 40'(t - {1'b0, dv});
        eq_nxt[j] = qi | (EV_N'(1) << (EV_N - 1 - j));
      end else begin
        er_nxt[j] = t[39:0];
        eq_nxt[j] = qi;
      end
    end
  end

  // side fields: carried forward, filled in where they are produced
  always_comb begin
    logic signed [24:0] xq;
    logic [DV_N-1:0]    q;
    logic signed [21:0] nt;
    side_nxt[1] = side_in_nxt;
    for (int s = 2; s < ST_LAST; s++) begin
      side_nxt[s] = side_r[s-1];
    end
    // clamp of the time position
    if (pr3_r > 43'(OUT_MAX)) begin
      side_nxt[4].pos_t = RES_W'(OUT_MAX);
      side_nxt[4].sat_t = 1'b1;
    end else if (pr3_r < 43'(OUT_MIN)) begin
      side_nxt[4].pos_t = RES_W'(OUT_MIN);
      side_nxt[4].sat_t = 1'b1;
    end else begin
      side_nxt[4].pos_t = pr3_r[RES_W-1:0];
      side_nxt[4].sat_t = 1'b0;
    end
    // charge position: round by 31 (includes the half), clamp, zero charge
    xq = 25'((qp_r + (56'sd1 <<< 30)) >>> 31);
    if (side_r[ST_POSQ-1].zq) begin
      side_nxt[ST_POSQ].pos_q = '0;
      side_nxt[ST_POSQ].sat_q = 1'b0;
    end else if (xq > 25'(OUT_MAX)) begin
      side_nxt[ST_POSQ].pos_q = RES_W'(OUT_MAX);
      side_nxt[ST_POSQ].sat_q = 1'b1;
    end else if (xq < 25'(OUT_MIN)) begin
      side_nxt[ST_POSQ].pos_q = RES_W'(OUT_MIN);
      side_nxt[ST_POSQ].sat_q = 1'b1;
    end else begin
      side_nxt[ST_POSQ].pos_q = xq[RES_W-1:0];
      side_nxt[ST_POSQ].sat_q = 1'b0;
    end
    // signed flight per metre; the quotient stays below 2^20 so never clamps
    q  = dq_r[DV_N-1];
    nt = side_r[ST_NTOF-1].neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    side_nxt[ST_NTOF].ntof = nt[RES_W-1:0];
    side_nxt[ST_NTOF].bad  = side_r[ST_NTOF-1].neg || (q == '0);
    // energy above range when the quotient would need more than 24 bits
    side_nxt[ST_EVS].ovf = (en_r >> EV_N) >= 44'(n2_r);
  end

  // output selection and status priority
  always_comb begin
    side_t                s;
    logic [ENERGY_W-1:0]  energy;
    logic                 sat;
    s = side_r[ST_LAST-1];
    if (!s.nt) begin
      energy = ENERGY_NONE;
    end else if (s.bad || s.ovf) begin
      energy = ENERGY_MAX;
    end else begin
      energy = ENERGY_W'(eq_r[EV_N-1]);
    end
    sat = s.sat_t || s.sat_q || (s.nt && !s.bad && s.ovf);
    if (s.zq) begin
      ostat_nxt = ST_ZERO_CHARGE;
    end else if (s.bad) begin
      ostat_nxt = ST_BAD_FLIGHT;
    end else if (sat) begin
      ostat_nxt = ST_SATURATED;
    end else begin
      ostat_nxt = ST_OK;
    end
    odata_nxt = {energy, s.ntof, s.pos_q, s.pos_t};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= ST_LAST; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_tvalid;
      for (int s = 2; s <= ST_LAST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 1; s < ST_LAST; s++) side_r[s] <= side_nxt[s];
      d1_r    <= d1_nxt;
      q1_r[0] <= in_tdata[79:64];
      q1_r[1] <= in_tdata[95:80];
      pph2_r  <= pph2_nxt;
      ppl2_r  <= ppl2_nxt;
      pr3_r   <= pr3_nxt;
      rad5_r  <= rad5_nxt;
      for (int l = 0; l < 2; l++) begin
        m2_r[l] <= m2_nxt[l];
        g2_r[l] <= g2_nxt[l];
        for (int j = 0; j < LG_N; j++) begin
          lm_r[l][j] <= lm_nxt[l][j];
          lg_r[l][j] <= lg_nxt[l][j];
        end
      end
      dl_r  <= dl_nxt;
      lnp_r <= lnp_nxt;
      ln_r  <= ln_nxt;
      qp_r  <= qp_nxt;
      for (int j = 0; j < SQ_N; j++) begin
        sqv_r[j] <= sqv_nxt[j];
        sqr_r[j] <= sqr_nxt[j];
      end
      ds_rem_r <= ds_rem_nxt;
      ds_low_r <= ds_low_nxt;
      ds_div_r <= ds_div_nxt;
      for (int j = 0; j < DV_N; j++) begin
        dr_r[j]  <= dr_nxt[j];
        dq_r[j]  <= dq_nxt[j];
        dd_r[j]  <= (j == 0) ? ds_div_r : dd_r[j-1];
        dlo_r[j] <= (j == 0) ? ds_low_r : dlo_r[j-1];
      end
      n2_r     <= n2_nxt;
      en_r     <= en_nxt;
      es_rem_r <= es_rem_nxt;
      es_low_r <= en_r[EV_N-1:0];
      es_div_r <= n2_r;
      for (int j = 0; j < EV_N; j++) begin
        er_r[j]  <= er_nxt[j];
        eq_r[j]  <= eq_nxt[j];
        ed_r[j]  <= (j == 0) ? es_div_r : ed_r[j-1];
        elo_r[j] <= (j == 0) ? es_low_r : elo_r[j-1];
      end
      odata_r <= odata_nxt;
      ostat_r <= ostat_nxt;
    end
  end

endmodule

>>> sv/scint_recon_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scint_recon_chk
// Port-level checks for the event reconstruction pipeline, bound to the top.
// ----------------------------------------------------------------------------
module scint_recon_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [scint_pkg::OUT_DW-1:0]  out_tdata,
  input logic [scint_pkg::OUT_UW-1:0]  out_tuser
);
  import scint_pkg::*;

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // the pipeline freezes as one, so input stalls whenever output stalls
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // zero charge reports a charge position of zero
  a_zero_q: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ZERO_CHARGE) |-> (out_tdata[41:21] == 21'd0))
    else $error("zero charge with nonzero charge position");

  // bad flight status goes with a non-positive flight per metre
  a_bad_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_BAD_FLIGHT)
    |-> (out_tdata[62] || (out_tdata[62:42] == 21'd0)))
    else $error("bad flight status with positive flight time");

endmodule

bind scintillator_event_reconstruct scint_recon_chk u_scint_recon_chk (.*);
